[design/alle_pkg.sv]
// ----------------------------------------------------------------------------
// alle_pkg
// Shared codes, widths and word types of the array linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int MAX_RESULTS = 16;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INS_HEAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_TAIL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_AFTER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_HEAD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_TAIL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_AFTER = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LIST      = 3'd6;
    // Kind 7 carries no operation
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SUCC   = 3'd4;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } res_t;

    // Write strobes toward the node store
    typedef struct packed {
        logic data_we;
        logic link_we;
    } mem_we_t;

endpackage

[design/array_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// array_linked_list_engine_core
// Singly linked list with a free list, kept in a store of NODE_COUNT slots.
// ----------------------------------------------------------------------------
// One operation is taken at a time; in_ready is high only between operations.
// Tail insert, tail delete, insert-after, delete-after and list walk the
// list through a node store with registered read data, one link per cycle;
// a list emits one element per cycle while the consumer takes them, capped
// at MAX_RESULTS (16) results, or NODE_COUNT if fewer. Results pass through a
// one-word output register, so a stalled consumer pauses the operation but
// never loses a word. There is no clearing pass after reset.
module array_linked_list_engine_core #(
    parameter int NODE_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [alle_pkg::KIND_W-1:0]   kind,
    input  logic signed [alle_pkg::DATA_W-1:0] key,
    input  logic signed [alle_pkg::DATA_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [alle_pkg::STATUS_W-1:0] status,
    output logic signed [alle_pkg::DATA_W-1:0] data_out,
    output logic [alle_pkg::SLOT_W-1:0]   slot,
    output logic                          last
);
    import alle_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);

    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [LW-1:0]     rd_link;
    mem_we_t           we;
    logic [IW-1:0]     data_wr_addr;
    logic [DATA_W-1:0] data_wr_value;
    logic [IW-1:0]     link_wr_addr;
    logic [LW-1:0]     link_wr_value;
    logic              res_push;
    logic              res_room;
    res_t              res;
    logic              out_valid_reg;
    res_t              out_res_reg;

    alle_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .IW         (IW),
        .LW         (LW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .key           (key),
        .value         (value),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .rd_link       (rd_link),
        .we            (we),
        .data_wr_addr  (data_wr_addr),
        .data_wr_value (data_wr_value),
        .link_wr_addr  (link_wr_addr),
        .link_wr_value (link_wr_value),
        .res_push      (res_push),
        .res_room      (res_room),
        .res           (res)
    );

    alle_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .IW         (IW),
        .LW         (LW)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .rd_link       (rd_link),
        .we            (we),
        .data_wr_addr  (data_wr_addr),
        .data_wr_value (data_wr_value),
        .link_wr_addr  (link_wr_addr),
        .link_wr_value (link_wr_value)
    );

    // Output word register: accept a new word when empty or being drained
    assign res_room = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign data_out  = out_res_reg.data;
    assign slot      = out_res_reg.slot;
    assign last      = out_res_reg.last;

endmodule

[design/alle_node_store.sv]
// ----------------------------------------------------------------------------
// alle_node_store
// Node data and link memories: one read port with registered data, one write
// port each. Link entries not yet written read as their reset link (i + 1).
// ----------------------------------------------------------------------------
module alle_node_store #(
    parameter int NODE_COUNT = 16,
    parameter int IW         = 4,
    parameter int LW         = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IW-1:0]             rd_addr,
    output logic [alle_pkg::DATA_W-1:0] rd_data,
    output logic [LW-1:0]             rd_link,
    input  alle_pkg::mem_we_t         we,
    input  logic [IW-1:0]             data_wr_addr,
    input  logic [alle_pkg::DATA_W-1:0] data_wr_value,
    input  logic [IW-1:0]             link_wr_addr,
    input  logic [LW-1:0]             link_wr_value
);
    import alle_pkg::*;

    logic [DATA_W-1:0]     data_mem [NODE_COUNT];
    logic [LW-1:0]         link_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] vld_reg;
    logic [DATA_W-1:0]     rd_data_reg;
    logic [LW-1:0]         rd_link_reg;

    // Mark link entries once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we.link_we)
        begin
            vld_reg[link_wr_addr] <= 1'b1;
        end
    end

    // Data memory: write, registered read
    always_ff @(posedge clk)
    begin
        if (we.data_we)
        begin
            data_mem[data_wr_addr] <= data_wr_value;
        end
        rd_data_reg <= data_mem[rd_addr];
    end

    // Link memory: write, registered read with reset link for unwritten entries
    always_ff @(posedge clk)
    begin
        if (we.link_we)
        begin
            link_mem[link_wr_addr] <= link_wr_value;
        end
        rd_link_reg <= vld_reg[rd_addr] ? link_mem[rd_addr] : (LW'(rd_addr) + LW'(1));
    end

    assign rd_data = rd_data_reg;
    assign rd_link = rd_link_reg;

endmodule

[design/alle_ctrl.sv]
// ----------------------------------------------------------------------------
// alle_ctrl
// Operation sequencer: holds head and free-list pointers, walks the list one
// link per cycle through the node store and produces result words.
// ----------------------------------------------------------------------------
module alle_ctrl #(
    parameter int NODE_COUNT = 16,
    parameter int IW         = 4,
    parameter int LW         = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [alle_pkg::KIND_W-1:0] kind,
    input  logic [alle_pkg::DATA_W-1:0] key,
    input  logic [alle_pkg::DATA_W-1:0] value,
    output logic [IW-1:0]               rd_addr,
    input  logic [alle_pkg::DATA_W-1:0] rd_data,
    input  logic [LW-1:0]               rd_link,
    output alle_pkg::mem_we_t           we,
    output logic [IW-1:0]               data_wr_addr,
    output logic [alle_pkg::DATA_W-1:0] data_wr_value,
    output logic [IW-1:0]               link_wr_addr,
    output logic [LW-1:0]               link_wr_value,
    output logic                        res_push,
    input  logic                        res_room,
    output alle_pkg::res_t              res
);
    import alle_pkg::*;

    localparam int LIST_CAP = (NODE_COUNT < MAX_RESULTS) ? NODE_COUNT : MAX_RESULTS;
    localparam int CW       = $clog2(LIST_CAP);
    localparam logic [LW-1:0] NIL = LW'(NODE_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS,
        S_DHEAD,
        S_DAFTER,
        S_WR2,
        S_LIST,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       free_reg, free_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [LW-1:0]       plink_reg, plink_next;
    logic [LW-1:0]       wr2_addr_reg, wr2_addr_next;
    logic [LW-1:0]       wr2_data_reg, wr2_data_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                link_nil;

    // Low slot bits of a node index, zero-extended for small stores
    function automatic logic [SLOT_W-1:0] to_slot(input logic [LW-1:0] s);
        logic [LW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, s};
        return w[SLOT_W-1:0];
    endfunction

    assign link_nil = (rd_link == NIL);
    assign in_ready = (state_reg == S_IDLE);

    // Sequence one operation
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        plink_next      = plink_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_data_next   = wr2_data_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_slot_next   = res_slot_reg;
        rd_addr         = cur_reg[IW-1:0];
        we              = '0;
        data_wr_addr    = free_reg[IW-1:0];
        data_wr_value   = value_reg;
        link_wr_addr    = cur_reg[IW-1:0];
        link_wr_value   = free_reg;
        res_push        = 1'b0;
        res.status      = res_status_reg;
        res.data        = res_data_reg;
        res.slot        = res_slot_reg;
        res.last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                // Start a new operation
                res_status_next = ST_OK;
                res_data_next   = '0;
                res_slot_next   = '0;
                if (in_valid)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    value_next = value;
                    prev_next  = NIL;
                    cnt_next   = '0;
                    cur_next   = head_reg;
                    rd_addr    = head_reg[IW-1:0];
                    case (kind) inside
                        KIND_INS_HEAD, KIND_INS_TAIL:
                        begin
                            if (free_reg == NIL)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                rd_addr    = free_reg[IW-1:0];
                                state_next = S_INS;
                            end
                        end
                        KIND_INS_AFTER, KIND_DEL_AFTER, KIND_DEL_TAIL:
                        begin
                            if (head_reg == NIL)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        KIND_DEL_HEAD:
                        begin
                            if (head_reg == NIL)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DHEAD;
                            end
                        end
                        KIND_LIST:
                        begin
                            if (head_reg == NIL)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // Unused code: drop without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                case (kind_reg) inside
                    KIND_INS_AFTER, KIND_DEL_AFTER:
                    begin
                        if (rd_data == key_reg)
                        begin
                            // Key found at the current node
                            wr2_addr_next = cur_reg;
                            plink_next    = rd_link;
                            if (kind_reg == KIND_INS_AFTER)
                            begin
                                if (free_reg == NIL)
                                begin
                                    res_status_next = ST_FULL;
                                    state_next      = S_RESP;
                                end
                                else
                                begin
                                    rd_addr    = free_reg[IW-1:0];
                                    state_next = S_INS;
                                end
                            end
                            else if (link_nil)
                            begin
                                res_status_next = ST_NO_SUCC;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                rd_addr    = rd_link[IW-1:0];
                                cur_next   = rd_link;
                                state_next = S_DAFTER;
                            end
                        end
                        else if (link_nil)
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            rd_addr  = rd_link[IW-1:0];
                            cur_next = rd_link;
                        end
                    end
                    KIND_INS_TAIL:
                    begin
                        if (link_nil)
                        begin
                            // Hook the new node behind the tail
                            we.link_we    = 1'b1;
                            link_wr_value = wr2_data_reg;
                            state_next    = S_RESP;
                        end
                        else
                        begin
                            rd_addr  = rd_link[IW-1:0];
                            cur_next = rd_link;
                        end
                    end
                    KIND_DEL_TAIL:
                    begin
                        if (link_nil)
                        begin
                            // Return the tail to the free list
                            we.link_we      = 1'b1;
                            free_next       = cur_reg;
                            res_data_next   = rd_data;
                            res_slot_next   = to_slot(cur_reg);
                            if (prev_reg == NIL)
                            begin
                                head_next  = NIL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                wr2_addr_next = prev_reg;
                                wr2_data_next = NIL;
                                state_next    = S_WR2;
                            end
                        end
                        else
                        begin
                            prev_next = cur_reg;
                            rd_addr   = rd_link[IW-1:0];
                            cur_next  = rd_link;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_INS:
            begin
                // Take the free head, store the value and link the node
                free_next     = rd_link;
                we.data_we    = 1'b1;
                we.link_we    = 1'b1;
                link_wr_addr  = free_reg[IW-1:0];
                wr2_data_next = free_reg;
                res_data_next = value_reg;
                res_slot_next = to_slot(free_reg);
                case (kind_reg)
                    KIND_INS_HEAD:
                    begin
                        link_wr_value = head_reg;
                        head_next     = free_reg;
                        state_next    = S_RESP;
                    end
                    KIND_INS_AFTER:
                    begin
                        link_wr_value = plink_reg;
                        state_next    = S_WR2;
                    end
                    default:
                    begin
                        link_wr_value = NIL;
                        if (head_reg == NIL)
                        begin
                            head_next  = free_reg;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            rd_addr    = head_reg[IW-1:0];
                            cur_next   = head_reg;
                            state_next = S_WALK;
                        end
                    end
                endcase
            end

            S_DHEAD:
            begin
                // Unlink the head and free it
                head_next     = rd_link;
                we.link_we    = 1'b1;
                free_next     = cur_reg;
                res_data_next = rd_data;
                res_slot_next = to_slot(cur_reg);
                state_next    = S_RESP;
            end

            S_DAFTER:
            begin
                // Bridge over the successor, then free it
                we.link_we    = 1'b1;
                link_wr_addr  = wr2_addr_reg[IW-1:0];
                link_wr_value = rd_link;
                wr2_addr_next = cur_reg;
                wr2_data_next = free_reg;
                free_next     = cur_reg;
                res_data_next = rd_data;
                res_slot_next = to_slot(cur_reg);
                state_next    = S_WR2;
            end

            S_WR2:
            begin
                we.link_we    = 1'b1;
                link_wr_addr  = wr2_addr_reg[IW-1:0];
                link_wr_value = wr2_data_reg;
                state_next    = S_RESP;
            end

            S_LIST:
            begin
                // Emit one element per cycle; hold the read while stalled
                res.status = ST_OK;
                res.data   = rd_data;
                res.slot   = to_slot(cur_reg);
                res.last   = link_nil || (cnt_reg == CW'(LIST_CAP - 1));
                if (res_room)
                begin
                    res_push = 1'b1;
                    if (res.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_addr  = rd_link[IW-1:0];
                        cur_next = rd_link;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (res_room)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            key_reg        <= '0;
            value_reg      <= '0;
            head_reg       <= NIL;
            free_reg       <= '0;
            cur_reg        <= '0;
            prev_reg       <= NIL;
            plink_reg      <= NIL;
            wr2_addr_reg   <= '0;
            wr2_data_reg   <= '0;
            cnt_reg        <= '0;
            res_status_reg <= ST_OK;
            res_data_reg   <= '0;
            res_slot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            head_reg       <= head_next;
            free_reg       <= free_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            plink_reg      <= plink_next;
            wr2_addr_reg   <= wr2_addr_next;
            wr2_data_reg   <= wr2_data_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_slot_reg   <= res_slot_next;
        end
    end

endmodule

[design/alle_checker.sv]
// ----------------------------------------------------------------------------
// alle_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module alle_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [alle_pkg::KIND_W-1:0]   kind,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [alle_pkg::STATUS_W-1:0] status,
    input logic [alle_pkg::DATA_W-1:0]   data_out,
    input logic [alle_pkg::SLOT_W-1:0]   slot,
    input logic                          last
);
    import alle_pkg::*;

    // A failed operation answers with exactly one marked, zeroed word
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && data_out == '0 && slot == '0))
        else $error("error status word not final or not zeroed");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY ||
                       status == ST_NOT_FOUND || status == ST_NO_SUCC))
        else $error("undefined status code");

    // An accepted operation that produces results closes the input side
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind != KIND_UNUSED) |=> !in_ready)
        else $error("input taken while an operation is in progress");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(data_out) && $stable(slot) &&
             $stable(last)))
        else $error("result word changed while stalled");

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data_out  (data_out),
    .slot      (slot),
    .last      (last)
);

[tb/sv/array_linked_list_engine_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_linked_list_engine_core_test
// Runs directed and random list operations through the engine. A software
// copy of the node store, the element list and the free list predicts every
// result word. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module array_linked_list_engine_core_test;
    import alle_pkg::*;

    localparam int NODES        = 16;
    localparam logic [4:0] NIL  = 5'd16;
    localparam int RANDOM_OPS   = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_SHOWN    = 10;

    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct {
        logic [KIND_W-1:0] op;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
    } list_op_t;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} mix_mode_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [KIND_W-1:0]          kind      = '0;
    logic signed [DATA_W-1:0]   key       = '0;
    logic signed [DATA_W-1:0]   value     = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   data_out;
    logic [SLOT_W-1:0]          slot;
    logic                       last;

    // Shadow of the node store
    logic [DATA_W-1:0] node_val [NODES];
    logic [4:0]        node_next [NODES];
    logic [4:0]        head_slot;
    logic [4:0]        free_slot;

    list_op_t op_backlog [$];
    res_t     op_replies [$];
    logic [DATA_W-1:0] word_pool [8];

    logic in_fire   = 1'b0;
    logic out_fire  = 1'b0;
    logic in_rush   = 1'b0;
    logic out_rush  = 1'b0;
    int   in_wait   = 0;
    int   out_wait  = 0;
    int   mismatches = 0;
    int   cycles    = 0;

    array_linked_list_engine_core #(
        .NODE_COUNT(NODES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .key      (key),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .data_out (data_out),
        .slot     (slot),
        .last     (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic push_reply(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] d,
                              input logic [4:0] s, input logic fin);
        res_t r;
        r.status = st;
        r.data   = d;
        r.slot   = s[SLOT_W-1:0];
        r.last   = fin;
        op_replies.push_back(r);
    endtask

    // First slot holding the key, or null
    function automatic logic [4:0] find_first(input logic [DATA_W-1:0] k);
        logic [4:0] s;
        s = head_slot;
        for (int n = 0; n < NODES && s != NIL; n++)
        begin
            if (node_val[s[3:0]] == k)
                return s;
            s = node_next[s[3:0]];
        end
        return NIL;
    endfunction

    // Apply one operation to the shadow store and queue its result words
    task automatic walk_list_op(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] k,
                                input logic [DATA_W-1:0] v);
        logic [4:0] s;
        logic [4:0] p;
        logic [4:0] d;
        logic [4:0] nx;
        int         n;
        case (op)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AFTER:
            begin
                p = NIL;
                if (op == KIND_INS_AFTER)
                begin
                    if (head_slot == NIL)
                    begin
                        push_reply(ST_EMPTY, '0, '0, 1'b1);
                        return;
                    end
                    p = find_first(k);
                    if (p == NIL)
                    begin
                        push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
                        return;
                    end
                end
                if (free_slot == NIL)
                begin
                    push_reply(ST_FULL, '0, '0, 1'b1);
                    return;
                end
                s = free_slot;
                free_slot = node_next[s[3:0]];
                node_val[s[3:0]] = v;
                if (op == KIND_INS_HEAD)
                begin
                    node_next[s[3:0]] = head_slot;
                    head_slot = s;
                end
                else if (op == KIND_INS_AFTER)
                begin
                    node_next[s[3:0]] = node_next[p[3:0]];
                    node_next[p[3:0]] = s;
                end
                else
                begin
                    node_next[s[3:0]] = NIL;
                    if (head_slot == NIL)
                        head_slot = s;
                    else
                    begin
                        p = head_slot;
                        for (n = 0; n < NODES && node_next[p[3:0]] != NIL; n++)
                            p = node_next[p[3:0]];
                        node_next[p[3:0]] = s;
                    end
                end
                push_reply(ST_OK, v, s, 1'b1);
            end
            KIND_DEL_HEAD:
            begin
                s = head_slot;
                if (s == NIL)
                begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                head_slot = node_next[s[3:0]];
                node_next[s[3:0]] = free_slot;
                free_slot = s;
                push_reply(ST_OK, node_val[s[3:0]], s, 1'b1);
            end
            KIND_DEL_TAIL:
            begin
                s = head_slot;
                if (s == NIL)
                begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                p = NIL;
                for (n = 0; n < NODES && node_next[s[3:0]] != NIL; n++)
                begin
                    p = s;
                    s = node_next[s[3:0]];
                end
                if (p != NIL)
                    node_next[p[3:0]] = NIL;
                else
                    head_slot = NIL;
                node_next[s[3:0]] = free_slot;
                free_slot = s;
                push_reply(ST_OK, node_val[s[3:0]], s, 1'b1);
            end
            KIND_DEL_AFTER:
            begin
                if (head_slot == NIL)
                begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                p = find_first(k);
                if (p == NIL)
                begin
                    push_reply(ST_NOT_FOUND, '0, '0, 1'b1);
                    return;
                end
                d = node_next[p[3:0]];
                if (d == NIL)
                begin
                    push_reply(ST_NO_SUCC, '0, '0, 1'b1);
                    return;
                end
                node_next[p[3:0]] = node_next[d[3:0]];
                node_next[d[3:0]] = free_slot;
                free_slot = d;
                push_reply(ST_OK, node_val[d[3:0]], d, 1'b1);
            end
            KIND_LIST:
            begin
                s = head_slot;
                if (s == NIL)
                begin
                    push_reply(ST_EMPTY, '0, '0, 1'b1);
                    return;
                end
                n = 0;
                while (s != NIL && n < MAX_RESULTS && n < NODES)
                begin
                    nx = node_next[s[3:0]];
                    push_reply(ST_OK, node_val[s[3:0]], s,
                               nx == NIL || n + 1 == MAX_RESULTS || n + 1 == NODES);
                    n++;
                    s = nx;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_op(input logic [KIND_W-1:0] op, input logic [DATA_W-1:0] k,
                            input logic [DATA_W-1:0] v);
        list_op_t w;
        w.op = op;
        w.k  = k;
        w.v  = v;
        op_backlog.push_back(w);
    endtask

    // Favor pool words so that searches hit stored values
    function automatic logic [DATA_W-1:0] pick_word(input int pool_odds);
        if ($urandom_range(0, 9) < pool_odds)
            return word_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [KIND_W-1:0] draw_op(input mix_mode_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
            begin
                if (r < 30) return KIND_INS_HEAD;
                if (r < 60) return KIND_INS_TAIL;
                if (r < 80) return KIND_INS_AFTER;
                if (r < 88) return KIND_LIST;
                if (r < 93) return KIND_DEL_AFTER;
                if (r < 96) return KIND_DEL_HEAD;
                if (r < 99) return KIND_DEL_TAIL;
                return KIND_UNUSED;
            end
            MODE_SHRINK:
            begin
                if (r < 8)  return KIND_INS_HEAD;
                if (r < 14) return KIND_INS_TAIL;
                if (r < 20) return KIND_INS_AFTER;
                if (r < 28) return KIND_LIST;
                if (r < 50) return KIND_DEL_HEAD;
                if (r < 72) return KIND_DEL_TAIL;
                if (r < 98) return KIND_DEL_AFTER;
                return KIND_UNUSED;
            end
            default:
            begin
                if (r < 14) return KIND_INS_HEAD;
                if (r < 28) return KIND_INS_TAIL;
                if (r < 42) return KIND_INS_AFTER;
                if (r < 56) return KIND_DEL_HEAD;
                if (r < 70) return KIND_DEL_TAIL;
                if (r < 84) return KIND_DEL_AFTER;
                if (r < 98) return KIND_LIST;
                return KIND_UNUSED;
            end
        endcase
    endfunction

    task automatic flag_word(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t %s: expected st=%0d d=%h sl=%0d l=%0d, got st=%0d d=%h sl=%0d l=%0d",
                     $time, what, want.status, want.data, want.slot, want.last,
                     got.status, got.data, got.slot, got.last);
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        mix_mode_t         mode;
        int                left;
        int                counted;
        logic [KIND_W-1:0] op;

        for (int i = 0; i < NODES; i++)
        begin
            node_val[i]  = '0;
            node_next[i] = 5'(i + 1);
        end
        head_slot = NIL;
        free_slot = '0;

        word_pool[0] = MOST_POS;
        word_pool[1] = MOST_NEG;
        word_pool[2] = '0;
        word_pool[3] = ALL_ONES;
        for (int i = 4; i < 8; i++)
            word_pool[i] = $urandom;

        // Empty list on every operation that reads it
        queue_op(KIND_LIST, '0, '0);
        queue_op(KIND_DEL_HEAD, '0, '0);
        queue_op(KIND_DEL_TAIL, '0, '0);
        queue_op(KIND_DEL_AFTER, MOST_POS, '0);
        queue_op(KIND_INS_AFTER, MOST_POS, 32'd1);
        // Build three nodes with extreme data, then probe the searches
        queue_op(KIND_INS_HEAD, '0, MOST_POS);
        queue_op(KIND_INS_TAIL, '0, MOST_NEG);
        queue_op(KIND_INS_AFTER, MOST_POS, ALL_ONES);
        queue_op(KIND_INS_AFTER, '0, 32'd5);
        queue_op(KIND_LIST, '0, '0);
        queue_op(KIND_DEL_AFTER, MOST_NEG, '0);
        queue_op(KIND_DEL_AFTER, MOST_POS, '0);
        queue_op(KIND_UNUSED, ALL_ONES, ALL_ONES);
        queue_op(KIND_DEL_AFTER, '0, '0);
        queue_op(KIND_DEL_TAIL, '0, '0);
        queue_op(KIND_DEL_HEAD, '0, '0);
        // Tail insert and tail delete on a one-node list
        queue_op(KIND_INS_TAIL, '0, '0);
        queue_op(KIND_DEL_TAIL, '0, '0);

        // Alternate fill, drain and mixed stretches
        counted = 0;
        left    = 0;
        mode    = MODE_MIXED;
        while (counted < RANDOM_OPS)
        begin
            if (left == 0)
            begin
                mode = (mode == MODE_GROW) ? MODE_SHRINK :
                       (mode == MODE_SHRINK) ? MODE_MIXED : MODE_GROW;
                left = $urandom_range(15, 30);
            end
            left--;
            op = draw_op(mode);
            queue_op(op, pick_word(8), pick_word(6));
            if (op != KIND_UNUSED)
                counted++;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || in_valid || op_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Note accepted words and predict their results
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                walk_list_op(kind, key, value);
        end
    end

    // Drive the next operation after its random gap
    always @(negedge clk)
    begin
        list_op_t nxt;
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (in_wait != 0)
            begin
                in_valid <= 1'b0;
                in_wait  <= in_wait - 1;
            end
            else if (op_backlog.size() != 0)
            begin
                nxt = op_backlog.pop_front();
                kind     <= nxt.op;
                key      <= nxt.k;
                value    <= nxt.v;
                in_valid <= 1'b1;
                in_wait  <= in_rush ? 0 : $urandom_range(0, 9);
                if ($urandom_range(0, 19) == 0)
                    in_rush <= !in_rush;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side for a random count after each word
    always @(negedge clk)
    begin
        int n;
        if (rst_n)
        begin
            if (out_fire)
            begin
                n = out_rush ? 0 : $urandom_range(0, 9);
                out_wait  <= n;
                out_ready <= (n == 0);
                if ($urandom_range(0, 19) == 0)
                    out_rush <= !out_rush;
            end
            else if (out_wait != 0)
            begin
                out_wait  <= out_wait - 1;
                out_ready <= (out_wait == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
            out_fire <= 1'b0;
        else
        begin
            out_fire <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                got.status = status;
                got.data   = data_out;
                got.slot   = slot;
                got.last   = last;
                if (op_replies.size() == 0)
                    flag_word("word with none pending", '0, got);
                else
                begin
                    want = op_replies.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.slot !== want.slot || got.last !== want.last)
                        flag_word("word mismatch", want, got);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

[filelist.f]
design/alle_pkg.sv
design/alle_node_store.sv
design/alle_ctrl.sv
design/array_linked_list_engine_core.sv
design/alle_checker.sv
tb/sv/array_linked_list_engine_core_test.sv
